>>> src/circular_deque_with_cursor_macros.svh
// assertion macros for the circular deque block
// used by circular_deque_with_cursor; expects clk and rst_n in scope
`ifndef CIRCULAR_DEQUE_WITH_CURSOR_MACROS_SVH
`define CIRCULAR_DEQUE_WITH_CURSOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define CDQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/cdq_pkg.sv
// shared types and constants for the circular deque block
// no dependencies
package cdq_pkg;

    localparam int MAX_SLOTS_DEF = 64;
    localparam int WORD_BITS_DEF = 32;

    localparam int KIND_W = 3;
    localparam int OFF_W  = 6;
    localparam int CAP_W  = 7;

    // capacity after reset
    localparam int CAP_RESET = 64;

    localparam logic [KIND_W-1:0] KIND_PUSH_HEAD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_TAIL   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_HEAD    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_TAIL    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CUR_HEAD    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CUR_TAIL    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_READ_CURSOR = 3'd6;
    localparam logic [KIND_W-1:0] KIND_FIND        = 3'd7;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FIND
    } state_t;

endpackage

>>> src/cdq_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/circular_deque_with_cursor.sv
// circular deque of words with head, tail and cursor, top level
// depends on cdq_pkg, cdq_ram and circular_deque_with_cursor_macros.svh

// A transaction is taken when start is high and busy is low. Push, pop, cursor
// placement and cursor read each take one ram read, and pushes and pops also
// write one slot. busy stays high while the transaction executes, so no new
// one is taken before it ends, and the result strobe done rises in the cycle
// after the execute state. A find reads the ring one slot per cycle through
// the single ram read port and stops at the first match or after the last
// slot of the ring. After reset and after every capacity write the ring is
// cleared one slot per cycle, busy high throughout (capacity clipped to
// 1..MAX_SLOTS). done lasts exactly one cycle and the receiver cannot hold it
// off. There is no empty or full check: a push into a full ring overwrites, a
// pop of an empty slot returns zero.
`include "circular_deque_with_cursor_macros.svh"

module circular_deque_with_cursor #(
    parameter int MAX_SLOTS = cdq_pkg::MAX_SLOTS_DEF,
    parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [cdq_pkg::CAP_W-1:0]   cfg_wr_data,
    input  logic                        start,
    output logic                        busy,
    input  logic [cdq_pkg::KIND_W-1:0]  kind,
    input  logic [WORD_BITS-1:0]        value,
    input  logic [cdq_pkg::OFF_W-1:0]   offset,
    output logic                        done,
    output logic [WORD_BITS-1:0]        word,
    output logic                        found,
    output logic                        bad_offset
);

    import cdq_pkg::*;

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int AW    = ((CNT_W > OFF_W) ? CNT_W : OFF_W) + 1;
    localparam int RST_SLOTS = (MAX_SLOTS < CAP_RESET) ? MAX_SLOTS : CAP_RESET;

    function automatic logic [CNT_W-1:0] ring_size_f(input logic [CAP_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == '0)
        begin
            r = CNT_W'(1);
        end
        else if (32'(c) > MAX_SLOTS)
        begin
            r = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            r = CNT_W'(c);
        end
        return r;
    endfunction

    state_t              state_reg, state_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [IDX_W-1:0]    cursor_reg, cursor_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;

    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [WORD_BITS-1:0] value_reg, value_next;
    logic [OFF_W-1:0]    offset_reg, offset_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic                found_reg, found_next;
    logic                bad_reg, bad_next;

    logic [CNT_W-1:0]    n;
    logic [CNT_W-1:0]    n_cfg;
    logic [IDX_W-1:0]    last_idx;
    logic                accept;
    logic                hit;
    logic                off_ge_n;
    logic [AW-1:0]       cur_from_head;
    logic [AW-1:0]       cur_from_tail;
    logic [IDX_W-1:0]    head_dec;
    logic [IDX_W-1:0]    head_inc;
    logic [IDX_W-1:0]    tail_dec;
    logic [IDX_W-1:0]    tail_inc;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    cdq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign n        = ring_size_f(cap_reg);
    assign n_cfg    = ring_size_f(cfg_wr_data);
    assign last_idx = IDX_W'(n - CNT_W'(1));
    assign accept   = start && (state_reg == ST_IDLE);
    assign hit      = (ram_rdata == value_reg);

    assign head_dec = (head_reg == '0) ? last_idx : head_reg - IDX_W'(1);
    assign head_inc = (head_reg == last_idx) ? '0 : head_reg + IDX_W'(1);
    assign tail_dec = (tail_reg == '0) ? last_idx : tail_reg - IDX_W'(1);
    assign tail_inc = (tail_reg == last_idx) ? '0 : tail_reg + IDX_W'(1);

    // offsets below n keep both sums under 2n, so one subtract wraps them
    assign off_ge_n = (AW'(offset_reg) >= AW'(n));
    always_comb
    begin
        cur_from_head = AW'(head_reg) + AW'(offset_reg);
        if (cur_from_head >= AW'(n))
        begin
            cur_from_head = cur_from_head - AW'(n);
        end
        cur_from_tail = AW'(tail_reg) + AW'(n) - AW'(offset_reg);
        if (cur_from_tail >= AW'(n))
        begin
            cur_from_tail = cur_from_tail - AW'(n);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == last_idx)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (kind == KIND_FIND) ? ST_FIND : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            ST_FIND:
            begin
                if (hit || (cnt_reg == last_idx))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_wr_en)
        begin
            state_next = ST_CLEAR;
        end
    end

    // datapath, ram controls and results
    always_comb
    begin
        cap_next    = cap_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cursor_next = cursor_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        kind_next   = kind_reg;
        value_next  = value_reg;
        offset_next = offset_reg;
        word_next   = word_reg;
        found_next  = found_reg;
        bad_next    = bad_reg;
        ram_we      = 1'b0;
        ram_waddr   = head_reg;
        ram_wdata   = '0;
        ram_raddr   = head_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                cnt_next  = cnt_reg + IDX_W'(1);
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next   = kind;
                    value_next  = value;
                    offset_next = offset;
                    cnt_next    = '0;
                    case (kind)
                        KIND_POP_TAIL:    ram_raddr = tail_reg;
                        KIND_READ_CURSOR: ram_raddr = cursor_reg;
                        KIND_FIND:        ram_raddr = '0;
                        default:          ram_raddr = head_reg;
                    endcase
                end
            end
            ST_EXEC:
            begin
                done_next  = 1'b1;
                found_next = 1'b0;
                bad_next   = 1'b0;
                word_next  = '0;
                case (kind_reg) inside
                    KIND_PUSH_HEAD:
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = head_dec;
                        ram_wdata   = value_reg;
                        head_next   = head_dec;
                        cursor_next = head_dec;
                    end
                    KIND_PUSH_TAIL:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = tail_inc;
                        ram_wdata = value_reg;
                        tail_next = tail_inc;
                    end
                    KIND_POP_HEAD:
                    begin
                        word_next   = ram_rdata;
                        ram_we      = 1'b1;
                        ram_waddr   = head_reg;
                        head_next   = head_inc;
                        cursor_next = head_inc;
                    end
                    KIND_POP_TAIL:
                    begin
                        word_next = ram_rdata;
                        ram_we    = 1'b1;
                        ram_waddr = tail_reg;
                        tail_next = tail_dec;
                    end
                    KIND_CUR_HEAD, KIND_CUR_TAIL:
                    begin
                        bad_next = off_ge_n;
                        if (!off_ge_n)
                        begin
                            cursor_next = (kind_reg == KIND_CUR_HEAD) ?
                                          IDX_W'(cur_from_head) : IDX_W'(cur_from_tail);
                        end
                    end
                    KIND_READ_CURSOR:
                    begin
                        word_next = ram_rdata;
                    end
                    default:
                    begin
                        word_next = '0;
                    end
                endcase
            end
            ST_FIND:
            begin
                ram_raddr = cnt_reg + IDX_W'(1);
                if (hit || (cnt_reg == last_idx))
                begin
                    done_next  = 1'b1;
                    found_next = hit;
                    bad_next   = 1'b0;
                    word_next  = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase

        // capacity write rebuilds the ring and restarts the clear sweep
        if (cfg_wr_en)
        begin
            cap_next    = cfg_wr_data;
            head_next   = '0;
            tail_next   = IDX_W'(n_cfg - CNT_W'(1));
            cursor_next = '0;
            cnt_next    = '0;
            done_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            cap_reg    <= CAP_W'(CAP_RESET);
            head_reg   <= '0;
            tail_reg   <= IDX_W'(RST_SLOTS - 1);
            cursor_reg <= '0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cap_reg    <= cap_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cursor_reg <= cursor_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        offset_reg <= offset_next;
        word_reg   <= word_next;
        found_reg  <= found_next;
        bad_reg    <= bad_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign word       = word_reg;
    assign found      = found_reg;
    assign bad_offset = bad_reg;

    `CDQ_ASSERT_NOW(a_done_after_work, done,
        $past(state_reg == ST_EXEC || state_reg == ST_FIND),
        "result strobe without a finished transaction")
    `CDQ_ASSERT_NOW(a_idx_in_ring, state_reg != ST_CLEAR,
        head_reg <= last_idx && tail_reg <= last_idx && cursor_reg <= last_idx,
        "ring index outside capacity")
    `CDQ_ASSERT_NOW(a_no_write_idle, ram_we, state_reg != ST_IDLE,
        "slot write while idle")
    `CDQ_ASSERT_NEXT(a_accept_busy, accept && !cfg_wr_en, busy,
        "not busy after a transaction was taken")

endmodule
